// File: hw/rtl/wcf_pkg.sv
// shared types, constants and crc helper for the word crc8 framer/deframer
`timescale 1ns / 1ps
`default_nettype none

package wcf_pkg;

    localparam int MAX_WORDS = 32;

    localparam int REQ_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 6;

    // words_seen must hold MAX_WORDS and still feed the 6-bit count field
    localparam int SEEN_MIN_W = $clog2(MAX_WORDS + 1);
    localparam int SEEN_W     = (SEEN_MIN_W > COUNT_W) ? SEEN_MIN_W : COUNT_W;

    // configuration registers
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_POLY = 1'b0;
    localparam logic REG_INIT = 1'b1;
    localparam logic [BYTE_W-1:0] POLY_RESET = 8'h31;
    localparam logic [BYTE_W-1:0] INIT_RESET = 8'hFF;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RX_BYTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RX_END  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TX_CMD  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TX_ARG  = 2'd3;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_WORD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TX_BYTE = 2'd2;

    typedef enum logic [1:0] {
        OP_RX_WORD,
        OP_SUMMARY,
        OP_TX_CMD,
        OP_TX_ARG
    } t_op;

    // work item handed from front to back
    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  hi;
        logic [BYTE_W-1:0]  lo;
        logic [BYTE_W-1:0]  chk;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    // msb-first crc-8 over one byte
    function automatic logic [BYTE_W-1:0] crc_byte(
        input logic [BYTE_W-1:0] poly,
        input logic [BYTE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] crc;
        crc = crc_in ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[BYTE_W-1]) begin
                crc = {crc[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                crc = {crc[BYTE_W-2:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wcf_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface wcf_req_if;
    import wcf_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [BYTE_W-1:0]   rx_byte;
    logic [WORD_W-1:0]   tx_word;

    modport source (output valid, output req_type, output rx_byte, output tx_word,
                    input ready);
    modport sink   (input valid, input req_type, input rx_byte, input tx_word,
                    output ready);
endinterface

interface wcf_res_if;
    import wcf_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   result_kind;
    logic [WORD_W-1:0]   word_out;
    logic [BYTE_W-1:0]   byte_out;
    logic                crc_ok;
    logic [COUNT_W-1:0]  words_count;
    logic                last_of_run;

    modport source (output valid, output result_kind, output word_out, output byte_out,
                    output crc_ok, output words_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input result_kind, input word_out, input byte_out,
                    input crc_ok, input words_count, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wcf_front.sv
// front end: accepts requests, groups received bytes, issues work items
`timescale 1ns / 1ps
`default_nettype none

module wcf_front import wcf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    wcf_req_if.sink    i_req,
    input  wire        i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_CHECK
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_held_high, n_held_high;
    logic [BYTE_W-1:0]   r_held_low, n_held_low;
    logic [SEEN_W-1:0]   r_words_seen, n_words_seen;
    logic                accept;
    logic [SEEN_W-1:0]   seen_inc;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && !i_full;

    // saturating word count
    assign seen_inc = (r_words_seen < SEEN_W'(MAX_WORDS)) ?
                      r_words_seen + SEEN_W'(1) : r_words_seen;

    always_comb begin
        n_phase      = r_phase;
        n_held_high  = r_held_high;
        n_held_low   = r_held_low;
        n_words_seen = r_words_seen;
        o_push       = 1'b0;
        o_cmd.op     = OP_TX_CMD;
        o_cmd.hi     = i_req.tx_word[WORD_W-1:BYTE_W];
        o_cmd.lo     = i_req.tx_word[BYTE_W-1:0];
        o_cmd.chk    = i_req.rx_byte;
        o_cmd.count  = r_words_seen[COUNT_W-1:0];
        if (accept) begin
            case (i_req.req_type)
                REQ_RX_BYTE: begin
                    case (r_phase)
                        PH_LOW: begin
                            n_held_low = i_req.rx_byte;
                            n_phase    = PH_CHECK;
                        end
                        PH_CHECK: begin
                            o_push       = 1'b1;
                            o_cmd.op     = OP_RX_WORD;
                            o_cmd.hi     = r_held_high;
                            o_cmd.lo     = r_held_low;
                            o_cmd.count  = seen_inc[COUNT_W-1:0];
                            n_words_seen = seen_inc;
                            n_phase      = PH_HIGH;
                        end
                        default: begin
                            n_held_high = i_req.rx_byte;
                            n_phase     = PH_LOW;
                        end
                    endcase
                end
                REQ_RX_END: begin
                    o_push       = 1'b1;
                    o_cmd.op     = OP_SUMMARY;
                    n_phase      = PH_HIGH;
                    n_held_high  = '0;
                    n_held_low   = '0;
                    n_words_seen = '0;
                end
                REQ_TX_CMD: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_TX_CMD;
                end
                default: begin
                    o_push   = 1'b1;
                    o_cmd.op = OP_TX_ARG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HIGH;
            r_held_high  <= '0;
            r_held_low   <= '0;
            r_words_seen <= '0;
        end else begin
            r_phase      <= n_phase;
            r_held_high  <= n_held_high;
            r_held_low   <= n_held_low;
            r_words_seen <= n_words_seen;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wcf_fifo.sv
// two-entry queue of work items between front and back
`timescale 1ns / 1ps
`default_nettype none

module wcf_fifo import wcf_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    input  wire   i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_cmd  o_cmd
);

    t_cmd        r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/wcf_back.sv
// back end: runs work items, computes crc, drives the result register
`timescale 1ns / 1ps
`default_nettype none

module wcf_back import wcf_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire [BYTE_W-1:0]  i_poly,
    input  wire [BYTE_W-1:0]  i_init,
    input  wire               i_empty,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    wcf_res_if.source         o_res
);

    typedef enum logic [1:0] {
        STEP_HIGH,
        STEP_LOW,
        STEP_CRC
    } t_step;

    t_step               r_step, n_step;
    logic [BYTE_W-1:0]   r_crc, n_crc;
    logic                r_all, n_all;
    logic                r_valid, n_valid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_ok, n_ok;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_last, n_last;
    logic                can_load;
    logic [BYTE_W-1:0]   crc_hi, crc_lo;
    logic                rx_ok;

    assign can_load = !r_valid || o_res.ready;
    assign crc_hi   = crc_byte(i_poly, i_init, i_cmd.hi);
    assign crc_lo   = crc_byte(i_poly, r_crc, i_cmd.lo);
    assign rx_ok    = (crc_lo == i_cmd.chk);

    always_comb begin
        n_step  = r_step;
        n_crc   = r_crc;
        n_all   = r_all;
        n_valid = r_valid && !o_res.ready;
        n_kind  = r_kind;
        n_word  = r_word;
        n_byte  = r_byte;
        n_ok    = r_ok;
        n_count = r_count;
        n_last  = r_last;
        o_pop   = 1'b0;
        if (!i_empty) begin
            case (i_cmd.op)
                OP_RX_WORD: begin
                    if (r_step == STEP_HIGH) begin
                        // first data byte folds in without a result
                        n_crc  = crc_hi;
                        n_step = STEP_LOW;
                    end else if (can_load) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_WORD;
                        n_word  = {i_cmd.hi, i_cmd.lo};
                        n_byte  = '0;
                        n_ok    = rx_ok;
                        n_count = i_cmd.count;
                        n_last  = 1'b1;
                        n_all   = r_all && rx_ok;
                        n_step  = STEP_HIGH;
                        o_pop   = 1'b1;
                    end
                end
                OP_SUMMARY: begin
                    if (can_load) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_SUMMARY;
                        n_word  = '0;
                        n_byte  = '0;
                        n_ok    = r_all;
                        n_count = i_cmd.count;
                        n_last  = 1'b1;
                        n_all   = 1'b1;
                        o_pop   = 1'b1;
                    end
                end
                default: begin
                    if (can_load) begin
                        n_valid = 1'b1;
                        n_kind  = KIND_TX_BYTE;
                        n_word  = '0;
                        n_ok    = 1'b0;
                        n_count = '0;
                        n_last  = 1'b0;
                        case (r_step)
                            STEP_HIGH: begin
                                n_byte = i_cmd.hi;
                                n_crc  = crc_hi;
                                n_step = STEP_LOW;
                            end
                            STEP_LOW: begin
                                n_byte = i_cmd.lo;
                                n_crc  = crc_lo;
                                if (i_cmd.op == OP_TX_CMD) begin
                                    // command words carry no crc byte
                                    n_last = 1'b1;
                                    n_step = STEP_HIGH;
                                    o_pop  = 1'b1;
                                end else begin
                                    n_step = STEP_CRC;
                                end
                            end
                            default: begin
                                n_byte = r_crc;
                                n_last = 1'b1;
                                n_step = STEP_HIGH;
                                o_pop  = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc   <= n_crc;
        r_kind  <= n_kind;
        r_word  <= n_word;
        r_byte  <= n_byte;
        r_ok    <= n_ok;
        r_count <= n_count;
        r_last  <= n_last;
        if (!i_rst_n) begin
            r_step  <= STEP_HIGH;
            r_all   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_all   <= n_all;
            r_valid <= n_valid;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.result_kind = r_kind;
    assign o_res.word_out    = r_word;
    assign o_res.byte_out    = r_byte;
    assign o_res.crc_ok      = r_ok;
    assign o_res.words_count = r_count;
    assign o_res.last_of_run = r_last;

endmodule

`default_nettype wire

// File: hw/rtl/word_crc8_framer_deframer_core.sv
// top level of the crc-8 protected 16-bit word framer and deframer
//
//  channel   dir   handshake        carries
//  i_req     in    valid / ready    req_type, rx_byte, tx_word
//  o_res     out   valid / ready    result_kind, word_out, byte_out, crc_ok,
//                                   words_count, last_of_run
//  apb       in    psel/penable     crc_polynomial (0x0), crc_initial (0x4)
//
//  a request is taken whenever the two-entry work queue has room; results leave at
//  most one per cycle while o_res.ready holds; an argument word gives high, low and
//  crc bytes, a command word high and low, a received word its result after folding
//  in its high byte, a summary one; bytes held in a group take no queue slot
//  reset is synchronous and clears the receive state and the queue; no clearing pass
//  a stalled result register holds the back end, the queue then fills and
//  only after that does i_req.ready fall
`timescale 1ns / 1ps
`default_nettype none

module word_crc8_framer_deframer_core import wcf_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    wcf_req_if.sink                 i_req,
    wcf_res_if.source               o_res,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire [CFG_ADDR_W-1:0]    paddr,
    input  wire [CFG_DATA_W-1:0]    pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready
);

    // configuration registers
    logic [BYTE_W-1:0]  r_crc_poly;
    logic [BYTE_W-1:0]  r_crc_init;
    logic               cfg_write;
    logic               reg_sel;

    // front to back queue
    logic   push, pop, full, empty;
    t_cmd   front_cmd, head_cmd;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly <= POLY_RESET;
            r_crc_init <= INIT_RESET;
        end else if (cfg_write) begin
            // registers are only 8 bits wide, upper data bits are dropped
            if (reg_sel == REG_POLY) begin
                r_crc_poly <= pwdata[BYTE_W-1:0];
            end else begin
                r_crc_init <= pwdata[BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == REG_INIT) begin
            prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, r_crc_init};
        end else begin
            prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, r_crc_poly};
        end
    end

    // byte grouping and request classification
    wcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    wcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    // crc checking, byte serialization and result register
    wcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_poly  (r_crc_poly),
        .i_init  (r_crc_init),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking testbench for the crc-8 protected word framer/deframer core
`timescale 1ns / 1ps

module tb;
    import wcf_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    // queue of two work items at up to three results each, with margin
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_ITEMS   = 40;
    localparam int LONG_WORDS    = MAX_WORDS + 1;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_DIRECTED  = 26;
    localparam int NUM_PHASES    = 4;

    // one result as seen on the output channel
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [WORD_W-1:0]  word;
        logic [BYTE_W-1:0]  txb;
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_frame_res;

    // one request plus up to three typed-in results (n_typed 0 means predicted)
    typedef struct packed {
        logic [REQ_W-1:0]  rt;
        logic [BYTE_W-1:0] rxb;
        logic [WORD_W-1:0] txw;
        logic [1:0]        n_typed;
        t_frame_res        t0;
        t_frame_res        t1;
        t_frame_res        t2;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    wcf_req_if req_ch ();
    wcf_res_if res_ch ();

    word_crc8_framer_deframer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block: configuration and receive state
    logic [BYTE_W-1:0] tb_poly;
    logic [BYTE_W-1:0] tb_init;
    logic [1:0]        grp_phase;
    logic [BYTE_W-1:0] grp_hi;
    logic [BYTE_W-1:0] grp_lo;
    int unsigned       rx_words;
    logic              rx_all_ok;

    t_frame_res  expected_results [$];
    t_frame_res  step_results [$];
    t_stim_row   dir_table [NUM_DIRECTED];
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned phase_items    = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // msb-first crc-8 over the 16 data bits, one bit per step
    function automatic logic [BYTE_W-1:0] word_crc8(input logic [WORD_W-1:0] w);
        logic [BYTE_W-1:0] c;
        logic              fb;
        c = tb_init;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            fb = c[BYTE_W-1] ^ w[i];
            c  = c << 1;
            if (fb) begin
                c = c ^ tb_poly;
            end
        end
        return c;
    endfunction

    function automatic t_frame_res mk_res(input logic [KIND_W-1:0] kind,
                                          input logic [WORD_W-1:0] word,
                                          input logic [BYTE_W-1:0] txb,
                                          input logic ok,
                                          input logic [COUNT_W-1:0] count,
                                          input logic last);
        return '{kind, word, txb, ok, count, last};
    endfunction

    function automatic t_stim_row row(input logic [REQ_W-1:0] rt,
                                      input logic [BYTE_W-1:0] rxb,
                                      input logic [WORD_W-1:0] txw,
                                      input logic [1:0] n = 2'd0,
                                      input t_frame_res t0 = '0,
                                      input t_frame_res t1 = '0,
                                      input t_frame_res t2 = '0);
        return '{rt, rxb, txw, n, t0, t1, t2};
    endfunction

    function automatic void clear_rx_state();
        grp_phase = 2'd0;
        grp_hi    = '0;
        grp_lo    = '0;
        rx_words  = 0;
        rx_all_ok = 1'b1;
    endfunction

    // advance the shadow by one request and collect the results it causes
    function automatic void frame_predict(input logic [REQ_W-1:0] rt,
                                          input logic [BYTE_W-1:0] rxb,
                                          input logic [WORD_W-1:0] txw);
        logic ok;
        step_results.delete();
        case (rt)
            REQ_RX_BYTE: begin
                if (grp_phase == 2'd0) begin
                    grp_hi    = rxb;
                    grp_phase = 2'd1;
                end else if (grp_phase == 2'd1) begin
                    grp_lo    = rxb;
                    grp_phase = 2'd2;
                end else begin
                    ok = (word_crc8({grp_hi, grp_lo}) == rxb);
                    // count saturates, crc still feeds the summary flag
                    if (rx_words < MAX_WORDS) begin
                        rx_words++;
                    end
                    rx_all_ok = rx_all_ok & ok;
                    grp_phase = 2'd0;
                    step_results.push_back(mk_res(KIND_WORD, {grp_hi, grp_lo}, '0, ok,
                                                  COUNT_W'(rx_words), 1'b1));
                end
            end
            REQ_RX_END: begin
                // a partial group is simply dropped here
                step_results.push_back(mk_res(KIND_SUMMARY, '0, '0, rx_all_ok,
                                              COUNT_W'(rx_words), 1'b1));
                clear_rx_state();
            end
            REQ_TX_CMD: begin
                step_results.push_back(mk_res(KIND_TX_BYTE, '0, txw[15:8], 1'b0, '0, 1'b0));
                step_results.push_back(mk_res(KIND_TX_BYTE, '0, txw[7:0], 1'b0, '0, 1'b1));
            end
            REQ_TX_ARG: begin
                step_results.push_back(mk_res(KIND_TX_BYTE, '0, txw[15:8], 1'b0, '0, 1'b0));
                step_results.push_back(mk_res(KIND_TX_BYTE, '0, txw[7:0], 1'b0, '0, 1'b0));
                step_results.push_back(mk_res(KIND_TX_BYTE, '0, word_crc8(txw), 1'b0, '0,
                                              1'b1));
            end
        endcase
    endfunction

    // present one request, wait for the handshake, then log its expectations
    task automatic send_row(input t_stim_row r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.rt;
        req_ch.rx_byte  <= r.rxb;
        req_ch.tx_word  <= r.txw;
        @(posedge i_clk);
        while (!req_ch.ready) begin
            @(posedge i_clk);
        end
        frame_predict(r.rt, r.rxb, r.txw);
        if (r.n_typed != 2'd0) begin
            // typed-in rows keep the shadow in step but check the literal values
            expected_results.push_back(r.t0);
            if (r.n_typed > 2'd1) begin
                expected_results.push_back(r.t1);
            end
            if (r.n_typed > 2'd2) begin
                expected_results.push_back(r.t2);
            end
        end else begin
            foreach (step_results[i]) begin
                expected_results.push_back(step_results[i]);
            end
        end
        phase_items++;
    endtask

    // well-formed receive transfer with random words, some bad crcs,
    // the odd transmit slipped in and sometimes a trailing partial group
    task automatic send_transfer(input int unsigned n_words);
        logic [WORD_W-1:0] w;
        logic [BYTE_W-1:0] chk;
        for (int unsigned k = 0; k < n_words; k++) begin
            w   = WORD_W'($urandom);
            chk = word_crc8(w);
            if ($urandom_range(99) < 20) begin
                chk = BYTE_W'($urandom);
            end
            send_row(row(REQ_RX_BYTE, w[15:8], WORD_W'($urandom)));
            if ($urandom_range(9) == 0) begin
                send_row(row($urandom_range(1) ? REQ_TX_ARG : REQ_TX_CMD,
                             BYTE_W'($urandom), WORD_W'($urandom)));
            end
            send_row(row(REQ_RX_BYTE, w[7:0], WORD_W'($urandom)));
            send_row(row(REQ_RX_BYTE, chk, WORD_W'($urandom)));
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(2, 1)) begin
                send_row(row(REQ_RX_BYTE, BYTE_W'($urandom), WORD_W'($urandom)));
            end
        end
        send_row(row(REQ_RX_END, BYTE_W'($urandom), WORD_W'($urandom)));
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic cfg_write(input logic idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_POLY) begin
            tb_poly = value;
        end else begin
            tb_init = value;
        end
    endtask

    // stop sending until every expected result is out, then let the core settle
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what, input t_frame_res want,
                                 input t_frame_res got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s at cycle %0d", what, cycle_count);
            $display("  exp kind=%0d word=%h byte=%h ok=%0d count=%0d last=%0d",
                     want.kind, want.word, want.txb, want.ok, want.count, want.last);
            $display("  got kind=%0d word=%h byte=%h ok=%0d count=%0d last=%0d",
                     got.kind, got.word, got.txb, got.ok, got.count, got.last);
        end
    endtask

    // receiver side: random back-pressure
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_frame_res got;
        t_frame_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.result_kind, res_ch.word_out, res_ch.byte_out, res_ch.crc_ok,
                    res_ch.words_count, res_ch.last_of_run};
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.word !== want.word ||
                    got.txb !== want.txb || got.ok !== want.ok ||
                    got.count !== want.count || got.last !== want.last) begin
                    note_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] poly_set [NUM_PHASES];
        logic [BYTE_W-1:0] init_set [NUM_PHASES];
        int unsigned       idle_set [NUM_PHASES];
        int unsigned       stall_set [NUM_PHASES];
        int unsigned       pick;
        bit                paused;

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_RX_BYTE;
        req_ch.rx_byte  = '0;
        req_ch.tx_word  = '0;
        tb_poly         = POLY_RESET;
        tb_init         = INIT_RESET;
        clear_rx_state();
        paused          = 1'b0;

        // register extremes, the usual setting and a random one
        poly_set  = '{8'h00, 8'hFF, POLY_RESET, BYTE_W'($urandom)};
        init_set  = '{8'h00, 8'hFF, INIT_RESET, BYTE_W'($urandom)};
        // no idling, sender idle, receiver stalling, both
        idle_set  = '{0, 58, 0, 21};
        stall_set = '{0, 0, 58, 21};

        // directed part, reset register values (poly 0x31, init 0xff)
        dir_table = '{
            // empty transfer right after reset
            row(REQ_RX_END, 8'h00, 16'h0000, 2'd1,
                mk_res(KIND_SUMMARY, 16'h0000, 8'h00, 1'b1, 6'd0, 1'b1)),
            row(REQ_TX_CMD, 8'h00, 16'hFF00, 2'd2,
                mk_res(KIND_TX_BYTE, 16'h0000, 8'hFF, 1'b0, 6'd0, 1'b0),
                mk_res(KIND_TX_BYTE, 16'h0000, 8'h00, 1'b0, 6'd0, 1'b1)),
            row(REQ_TX_CMD, 8'hFF, 16'h00FF),
            // textbook check value: 0xbeef gives 0x92
            row(REQ_TX_ARG, 8'h00, 16'hBEEF, 2'd3,
                mk_res(KIND_TX_BYTE, 16'h0000, 8'hBE, 1'b0, 6'd0, 1'b0),
                mk_res(KIND_TX_BYTE, 16'h0000, 8'hEF, 1'b0, 6'd0, 1'b0),
                mk_res(KIND_TX_BYTE, 16'h0000, 8'h92, 1'b0, 6'd0, 1'b1)),
            row(REQ_TX_ARG, 8'h00, 16'h0000),
            row(REQ_TX_ARG, 8'hFF, 16'hFFFF),
            // the same word coming back in
            row(REQ_RX_BYTE, 8'hBE, 16'h0000),
            row(REQ_RX_BYTE, 8'hEF, 16'h0000),
            row(REQ_RX_BYTE, 8'h92, 16'h0000, 2'd1,
                mk_res(KIND_WORD, 16'hBEEF, 8'h00, 1'b1, 6'd1, 1'b1)),
            row(REQ_RX_BYTE, 8'h00, 16'h0000),
            row(REQ_RX_BYTE, 8'h00, 16'h0000),
            row(REQ_RX_BYTE, 8'h00, 16'h0000),
            row(REQ_RX_BYTE, 8'hFF, 16'hFFFF),
            row(REQ_RX_BYTE, 8'hFF, 16'hFFFF),
            row(REQ_RX_BYTE, 8'hFF, 16'hFFFF),
            // transmits between received bytes leave the group alone
            row(REQ_RX_BYTE, 8'h12, 16'hFFFF),
            row(REQ_TX_CMD, 8'h00, 16'hA55A),
            row(REQ_RX_BYTE, 8'h34, 16'h0000),
            row(REQ_TX_ARG, 8'h00, 16'h1234),
            row(REQ_RX_BYTE, 8'h37, 16'h0000),
            // partial group dropped at end of receive
            row(REQ_RX_BYTE, 8'h56, 16'h0000),
            row(REQ_RX_END, 8'h00, 16'h0000),
            row(REQ_RX_END, 8'hFF, 16'hFFFF, 2'd1,
                mk_res(KIND_SUMMARY, 16'h0000, 8'h00, 1'b1, 6'd0, 1'b1)),
            row(REQ_RX_BYTE, 8'hAB, 16'h0000),
            row(REQ_RX_BYTE, 8'hCD, 16'h0000),
            row(REQ_RX_END, 8'h00, 16'h0000)
        };

        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i]) begin
            send_row(dir_table[i]);
        end
        wait_drained();

        // random part, one register setting and idling pattern per phase
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = idle_set[ph];
            recv_stall_pct = stall_set[ph];
            cfg_write(REG_POLY, poly_set[ph]);
            cfg_write(REG_INIT, init_set[ph]);
            phase_items = 0;
            // one transfer long enough to hit the word count ceiling
            if (ph == 2) begin
                send_transfer(LONG_WORDS);
            end
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    send_transfer($urandom_range(6));
                end else if (pick < 85) begin
                    send_row(row($urandom_range(1) ? REQ_TX_ARG : REQ_TX_CMD,
                                 BYTE_W'($urandom), WORD_W'($urandom)));
                end else begin
                    // noise: any request code with any payload
                    send_row(row(REQ_W'($urandom_range(3)), BYTE_W'($urandom),
                                 WORD_W'($urandom)));
                end
                // sender holds off once until the core has emptied out
                if (ph == 1 && !paused && phase_items >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
            // close any open group so the next setting starts clean
            send_row(row(REQ_RX_END, BYTE_W'($urandom), WORD_W'($urandom)));
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
